// ===== rtl/sffp_pkg.sv =====
// Shared types and constants for the first-fit spectrum placer.
// Used by sffp_front, sffp_back and spectrum_first_fit_placer; no dependencies.
package sffp_pkg;

  localparam int SLICES  = 64;
  localparam int PATHS   = 8;
  localparam int SLICE_W = $clog2(SLICES);
  localparam int PATH_W  = $clog2(PATHS);
  localparam int CNT_W   = 7;
  localparam int ADJ_W   = 8;
  localparam int CFG_W   = 64;
  localparam int WORD_W  = 64;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PLACE = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SKIP,
    OP_PLACE,
    OP_ZERO,
    OP_FAIL
  } op_t;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        path_id;
    logic [WORD_W-1:0] occupancy_word;
    logic [CNT_W-1:0]  slice_count;
    logic              last_in_batch;
  } in_item_t;

  typedef struct packed {
    logic [5:0] start_slice;
    logic       placed;
    logic       batch_ok;
    logic       batch_done;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [PATH_W-1:0] path;
    logic [SLICES-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/spectrum_first_fit_placer.sv =====
// Top level of the first-fit spectrum placer: front queue plus back-end engine.
// Depends on sffp_pkg, sffp_front and sffp_back.
// Loads, zero-slice and rejected placements go from ST_IDLE straight to ST_FINISH,
// which registers the result strobe. Placements first scan up to SLICES (64) slices
// in ST_SCAN. Items are popped only in ST_IDLE, so each finishes before the next.
// Reset (rst_n low, synchronous) clears stores, batch state and the adjacency register.
module spectrum_first_fit_placer import sffp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  q_head_t head;
  logic    pop;

  sffp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  sffp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/sffp_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on sffp_pkg.
module sffp_front import sffp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output q_head_t  head,
  input  logic     pop
);

  entry_t            ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  entry_t            new_ent;
  logic              path_ok;
  logic              push;

  always_comb begin
    path_ok = int'(in_item.path_id) < PATHS;
    new_ent.path  = in_item.path_id[PATH_W-1:0];
    new_ent.word  = in_item.occupancy_word[SLICES-1:0];
    new_ent.count = in_item.slice_count;
    new_ent.last  = 1'b0;
    if (in_item.req_type == REQ_LOAD) begin
      new_ent.op = path_ok ? OP_LOAD : OP_SKIP;
    end else begin
      new_ent.last = in_item.last_in_batch;
      if (!path_ok || in_item.slice_count > CNT_W'(SLICES)) begin
        new_ent.op = OP_FAIL;
      end else if (in_item.slice_count == '0) begin
        new_ent.op = OP_ZERO;
      end else begin
        new_ent.op = OP_PLACE;
      end
    end
  end

  assign busy       = (cnt_r == QCNT_W'(QDEPTH));
  assign push       = start && !busy;
  assign head.valid = (cnt_r != '0);
  assign head.entry = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= new_ent;
        wr_ptr_r        <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + QCNT_W'(1)) else $error("lost push");

endmodule

// ===== rtl/sffp_back.sv =====
// Back end: runs loads and first-fit placements against the occupancy stores.
// Depends on sffp_pkg; fed by sffp_front.
module sffp_back import sffp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_head_t          head,
  output logic             pop,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             out_valid,
  output out_item_t        out_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t             state_r;
  entry_t             cur_r;
  logic [SLICES-1:0]  base_r    [PATHS];
  logic [SLICES-1:0]  scratch_r [PATHS];
  logic [SLICES-1:0]  word_r;
  logic [SLICE_W-1:0] idx_r;
  logic [SLICE_W-1:0] start_r;
  logic [CNT_W-1:0]   run_r;
  logic               found_r;
  logic               failed_r;
  logic [CFG_W-1:0]   cfg_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               free;
  logic [CNT_W-1:0]   run_inc;
  logic               hit;
  logic               last_slice;
  logic [SLICES-1:0]  run_m;
  logic [ADJ_W-1:0]   adj;
  logic               is_req;
  logic               placed;
  logic               fail_now;

  always_comb begin
    free       = !word_r[0];
    run_inc    = run_r + CNT_W'(1);
    hit        = free && (run_inc == cur_r.count);
    last_slice = (idx_r == SLICE_W'(SLICES - 1));
    run_m      = ({SLICES{1'b1}} >> (CNT_W'(SLICES) - cur_r.count)) << start_r;
    adj        = cfg_r[ADJ_W*cur_r.path +: ADJ_W];
    is_req     = (cur_r.op == OP_PLACE) || (cur_r.op == OP_ZERO) || (cur_r.op == OP_FAIL);
    placed     = ((cur_r.op == OP_PLACE) && found_r) || (cur_r.op == OP_ZERO);
    fail_now   = is_req && !placed;
  end

  assign pop       = (state_r == ST_IDLE) && head.valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      failed_r    <= 1'b0;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PATHS; p++) begin
        base_r[p]    <= '0;
        scratch_r[p] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            cur_r   <= head.entry;
            word_r  <= scratch_r[head.entry.path];
            idx_r   <= '0;
            run_r   <= '0;
            found_r <= 1'b0;
            state_r <= (head.entry.op == OP_PLACE) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          word_r <= word_r >> 1;
          idx_r  <= idx_r + SLICE_W'(1);
          run_r  <= free ? run_inc : '0;
          if (hit) begin
            found_r <= 1'b1;
            start_r <= SLICE_W'(CNT_W'(idx_r) + CNT_W'(1) - cur_r.count);
            state_r <= ST_FINISH;
          end else if (last_slice) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cur_r.op == OP_LOAD) begin
            base_r[cur_r.path]    <= cur_r.word;
            scratch_r[cur_r.path] <= cur_r.word;
          end
          if ((cur_r.op == OP_PLACE) && found_r) begin
            for (int j = 0; j < PATHS; j++) begin
              if (adj[j] || (cur_r.path == PATH_W'(j))) begin
                scratch_r[j] <= scratch_r[j] | run_m;
              end
            end
          end
          out_valid_r            <= 1'b1;
          out_item_r.start_slice <= ((cur_r.op == OP_PLACE) && found_r) ? 6'(start_r) : '0;
          out_item_r.placed      <= placed;
          out_item_r.batch_ok    <= !(failed_r || fail_now);
          out_item_r.batch_done  <= is_req && cur_r.last;
          if (is_req && cur_r.last) begin
            failed_r <= 1'b0;
            for (int p = 0; p < PATHS; p++) begin
              scratch_r[p] <= base_r[p];
            end
          end else if (fail_now) begin
            failed_r <= 1'b1;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_FINISH) else $error("stray result strobe");
  a_unplaced_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.placed) |-> out_item_r.start_slice == '0)
    else $error("unplaced result with nonzero start");
  a_scan_place_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cur_r.op == OP_PLACE) else $error("scan on non-place item");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r != ST_IDLE) else $error("popped item not taken");

endmodule
